### rtl/core/vssr_pkg.sv
// Package for the vertex shift/scale/rotate block: word types, mode and
// register codes, lane control struct and reset constants.
// No dependencies.
`timescale 1ns / 1ps

package vssr_pkg;

  typedef struct packed {
    logic signed [31:0] x_in;
    logic signed [31:0] y_in;
    logic signed [31:0] z_in;
    logic               last_in;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] x_out;
    logic signed [31:0] y_out;
    logic signed [31:0] z_out;
    logic               last_out;
  } out_word_t;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [2:0] {
    MODE_SHIFT = 3'd0,
    MODE_SCALE = 3'd1,
    MODE_ROT_X = 3'd2,
    MODE_ROT_Y = 3'd3,
    MODE_ROT_Z = 3'd4
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE     = 3'd0,
    REG_CENTER_X = 3'd1,
    REG_CENTER_Y = 3'd2,
    REG_CENTER_Z = 3'd3,
    REG_SCALE    = 3'd4,
    REG_COS      = 3'd5,
    REG_SIN      = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    OP_PASS  = 2'd0,
    OP_SHIFT = 2'd1,
    OP_SCALE = 2'd2,
    OP_ROT   = 2'd3
  } lane_op_t;

  typedef enum logic [1:0] {
    COORD_X = 2'd0,
    COORD_Y = 2'd1,
    COORD_Z = 2'd2
  } coord_t;

  typedef struct packed {
    lane_op_t op;
    coord_t   b_sel;
    logic     neg;
  } lane_ctl_t;

  // 1.0 in Q16.16 and in Q2.30.
  localparam logic signed [31:0] SCALE_ONE = 32'sh0001_0000;
  localparam logic signed [31:0] TRIG_ONE  = 32'sh4000_0000;

endpackage

### rtl/core/vssr_decode.sv
// Mode decoder: turns the configured mode into one control word per lane.
// Depends on vssr_pkg.
`timescale 1ns / 1ps

module vssr_decode (
  input  vssr_pkg::mode_t     mode_i,
  output vssr_pkg::lane_ctl_t ctl_x_o,
  output vssr_pkg::lane_ctl_t ctl_y_o,
  output vssr_pkg::lane_ctl_t ctl_z_o
);
  import vssr_pkg::*;

  // A lane always multiplies its own coordinate by cosine; b_sel picks the
  // coordinate that goes with sine, and neg flips the sine term.
  always_comb begin
    ctl_x_o = '{op: OP_PASS, b_sel: COORD_X, neg: 1'b0};
    ctl_y_o = '{op: OP_PASS, b_sel: COORD_X, neg: 1'b0};
    ctl_z_o = '{op: OP_PASS, b_sel: COORD_X, neg: 1'b0};
    case (mode_i)
      MODE_SHIFT: begin
        ctl_x_o.op = OP_SHIFT;
        ctl_y_o.op = OP_SHIFT;
        ctl_z_o.op = OP_SHIFT;
      end
      MODE_SCALE: begin
        ctl_x_o.op = OP_SCALE;
        ctl_y_o.op = OP_SCALE;
        ctl_z_o.op = OP_SCALE;
      end
      MODE_ROT_X: begin
        ctl_y_o = '{op: OP_ROT, b_sel: COORD_Z, neg: 1'b0};
        ctl_z_o = '{op: OP_ROT, b_sel: COORD_Y, neg: 1'b1};
      end
      MODE_ROT_Y: begin
        ctl_x_o = '{op: OP_ROT, b_sel: COORD_Z, neg: 1'b0};
        ctl_z_o = '{op: OP_ROT, b_sel: COORD_X, neg: 1'b1};
      end
      MODE_ROT_Z: begin
        ctl_x_o = '{op: OP_ROT, b_sel: COORD_Y, neg: 1'b0};
        ctl_y_o = '{op: OP_ROT, b_sel: COORD_X, neg: 1'b1};
      end
      default: begin
        // Unused codes leave the vertex untouched.
      end
    endcase
  end

endmodule

### rtl/core/vssr_lane.sv
// One coordinate lane: subtract, two multipliers, then shift/add and
// saturation. Two register stages; the saturated result is combinational.
// Depends on vssr_pkg.
`timescale 1ns / 1ps

module vssr_lane (
  input  logic                clk,
  input  logic                ld_i,
  input  logic                adv_i,
  input  vssr_pkg::lane_ctl_t ctl_i,
  input  logic signed [31:0]  a_i,
  input  logic signed [31:0]  b_i,
  input  logic signed [31:0]  center_i,
  input  logic signed [31:0]  scale_i,
  input  logic signed [31:0]  cos_i,
  input  logic signed [31:0]  sin_i,
  output logic signed [31:0]  res_o
);
  import vssr_pkg::*;

  localparam int unsigned WIDE_W = 68;

  logic signed [31:0]       a1_r, b1_r, a2_r;
  logic signed [32:0]       d1_r, d2_r;
  logic signed [32:0]       mul_a, mul_b, k2;
  logic signed [65:0]       m1_r, m2_r;
  logic signed [WIDE_W-1:0] wide;

  always_ff @(posedge clk) begin
    if (ld_i) begin
      a1_r <= a_i;
      b1_r <= b_i;
      d1_r <= 33'(a_i) - 33'(center_i);
    end
  end

  always_comb begin
    mul_a = (ctl_i.op == OP_SCALE) ? d1_r : 33'(a1_r);
    mul_b = (ctl_i.op == OP_SCALE) ? 33'(scale_i) : 33'(cos_i);
    // Negated sine needs 33 bits: the most negative input becomes 2^31.
    k2    = ctl_i.neg ? -33'(sin_i) : 33'(sin_i);
  end

  always_ff @(posedge clk) begin
    if (adv_i) begin
      m1_r <= 66'(mul_a) * 66'(mul_b);
      m2_r <= 66'(b1_r) * 66'(k2);
      d2_r <= d1_r;
      a2_r <= a1_r;
    end
  end

  always_comb begin
    case (ctl_i.op)
      OP_PASS:  wide = WIDE_W'(a2_r);
      OP_SHIFT: wide = WIDE_W'(d2_r);
      OP_SCALE: wide = (WIDE_W'(m1_r) >>> 16) + WIDE_W'(center_i);
      OP_ROT:   wide = (WIDE_W'(m1_r) + WIDE_W'(m2_r)) >>> 30;
      default:  wide = WIDE_W'(a2_r);
    endcase
  end

  // The value fits when bit 31 and every bit above it match the sign.
  always_comb begin
    if (wide[WIDE_W-1:31] == {(WIDE_W-31){wide[WIDE_W-1]}}) begin
      res_o = wide[31:0];
    end else if (wide[WIDE_W-1]) begin
      res_o = 32'sh8000_0000;
    end else begin
      res_o = 32'sh7fff_ffff;
    end
  end

endmodule

### rtl/core/vssr_merge.sv
// Output stage: collects the three lane results and the last flag into one
// registered result word with its strobe. Depends on vssr_pkg.
`timescale 1ns / 1ps

module vssr_merge (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                valid_i,
  input  logic signed [31:0]  x_i,
  input  logic signed [31:0]  y_i,
  input  logic signed [31:0]  z_i,
  input  logic                last_i,
  output logic                valid_o,
  output vssr_pkg::out_word_t data_o
);
  import vssr_pkg::*;

  logic      valid_r;
  out_word_t data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_i) begin
      data_r <= '{x_out: x_i, y_out: y_i, z_out: z_i, last_out: last_i};
    end
  end

  assign valid_o = valid_r;
  assign data_o  = data_r;

endmodule

### rtl/core/vertex_shift_scale_rotate_top.sv
// Top level of the vertex shift/scale/rotate block: configuration registers,
// three coordinate lanes and the output stage.
// Depends on vssr_pkg, vssr_decode, vssr_lane and vssr_merge.
`timescale 1ns / 1ps

// Usage:
// Input: drive a vertex word on in_data and raise start; the word is taken at
// every rising edge where start is high and busy is low. busy stays low, so
// one vertex can be taken every cycle with no gaps.
// Output: each vertex comes back as one word on out_data, marked by out_valid
// for exactly one cycle. Words come back in input order. The receiver cannot
// stall the block; it must take every strobed word.
// Throughput is one vertex per cycle. The pipeline is subtract, multiply,
// then sum/shift/saturate into the output register.
// Configuration: cfg_we with cfg_idx and cfg_wdata writes one register per
// edge (mode, center x/y/z, scale, cosine, sine); indexes past sine are
// ignored. Write only while no vertex is in flight.
// Reset (rst_n low at a clock edge) empties the pipeline and restores the
// registers: shift mode, zero center, scale 1.0, cosine 1.0, sine 0.
module vertex_shift_scale_rotate_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  vssr_pkg::in_word_t                  in_data,
  output logic                                out_valid,
  output vssr_pkg::out_word_t                 out_data,
  input  logic                                cfg_we,
  input  logic [vssr_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [vssr_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import vssr_pkg::*;

  mode_t              mode_r;
  logic signed [31:0] center_x_r, center_y_r, center_z_r;
  logic signed [31:0] scale_r, cos_r, sin_r;

  logic               accept;
  logic               v1_r, v2_r;
  logic               last1_r, last2_r;
  lane_ctl_t          ctl_x, ctl_y, ctl_z;
  logic signed [31:0] b_x, b_y, b_z;
  logic signed [31:0] res_x, res_y, res_z;

  // Every cycle is open for a new vertex.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_SHIFT;
      center_x_r <= '0;
      center_y_r <= '0;
      center_z_r <= '0;
      scale_r    <= SCALE_ONE;
      cos_r      <= TRIG_ONE;
      sin_r      <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_idx))
        REG_MODE:     mode_r     <= mode_t'(cfg_wdata[2:0]);
        REG_CENTER_X: center_x_r <= cfg_wdata;
        REG_CENTER_Y: center_y_r <= cfg_wdata;
        REG_CENTER_Z: center_z_r <= cfg_wdata;
        REG_SCALE:    scale_r    <= cfg_wdata;
        REG_COS:      cos_r      <= cfg_wdata;
        REG_SIN:      sin_r      <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= accept;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      last1_r <= in_data.last_in;
    end
    if (v1_r) begin
      last2_r <= last1_r;
    end
  end

  vssr_decode u_decode (
    .mode_i  (mode_r),
    .ctl_x_o (ctl_x),
    .ctl_y_o (ctl_y),
    .ctl_z_o (ctl_z)
  );

  function automatic logic signed [31:0] pick(input coord_t sel,
                                              input in_word_t w);
    logic signed [31:0] r;
    case (sel)
      COORD_X: r = w.x_in;
      COORD_Y: r = w.y_in;
      COORD_Z: r = w.z_in;
      default: r = w.x_in;
    endcase
    return r;
  endfunction

  assign b_x = pick(ctl_x.b_sel, in_data);
  assign b_y = pick(ctl_y.b_sel, in_data);
  assign b_z = pick(ctl_z.b_sel, in_data);

  vssr_lane u_lane_x (
    .clk      (clk),
    .ld_i     (accept),
    .adv_i    (v1_r),
    .ctl_i    (ctl_x),
    .a_i      (in_data.x_in),
    .b_i      (b_x),
    .center_i (center_x_r),
    .scale_i  (scale_r),
    .cos_i    (cos_r),
    .sin_i    (sin_r),
    .res_o    (res_x)
  );

  vssr_lane u_lane_y (
    .clk      (clk),
    .ld_i     (accept),
    .adv_i    (v1_r),
    .ctl_i    (ctl_y),
    .a_i      (in_data.y_in),
    .b_i      (b_y),
    .center_i (center_y_r),
    .scale_i  (scale_r),
    .cos_i    (cos_r),
    .sin_i    (sin_r),
    .res_o    (res_y)
  );

  vssr_lane u_lane_z (
    .clk      (clk),
    .ld_i     (accept),
    .adv_i    (v1_r),
    .ctl_i    (ctl_z),
    .a_i      (in_data.z_in),
    .b_i      (b_z),
    .center_i (center_z_r),
    .scale_i  (scale_r),
    .cos_i    (cos_r),
    .sin_i    (sin_r),
    .res_o    (res_z)
  );

  vssr_merge u_merge (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (v2_r),
    .x_i     (res_x),
    .y_i     (res_y),
    .z_i     (res_z),
    .last_i  (last2_r),
    .valid_o (out_valid),
    .data_o  (out_data)
  );

  a_accept_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##3 out_valid)
    else $error("accepted vertex did not come out after three cycles");

  a_out_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, 3))
    else $error("result strobe without an accepted vertex");

  a_last_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.last_out == $past(in_data.last_in, 3))
    else $error("last flag does not match its vertex");

endmodule

### verif/vertex_shift_scale_rotate_top_tb.sv
// Self-checking testbench for vertex_shift_scale_rotate_top: directed vertices and
// random bursts over many register settings, checked against a built-in predictor.
// Depends on vssr_pkg and the vertex_shift_scale_rotate_top RTL.
`timescale 1ns / 1ps

module vertex_shift_scale_rotate_top_tb;
  import vssr_pkg::*;

  typedef logic signed [95:0] wide_t;

  typedef struct {
    logic        is_write;
    logic [2:0]  reg_idx;
    logic [31:0] reg_val;
    in_word_t    vertex;
    logic        typed;
    out_word_t   want;
  } plan_step_t;

  localparam logic signed [31:0] I32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] I32_MIN = 32'sh8000_0000;
  localparam logic [2:0] MODE_SPARE_LO = 3'd5;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;
  localparam logic [2:0] REG_NONE      = 3'd7;
  localparam int PHASES       = 12;
  localparam int PHASE_WORDS  = 120;
  localparam int SHOWN_ERRORS = 10;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  start     = 1'b0;
  logic                  busy;
  in_word_t              in_data   = '0;
  logic                  out_valid;
  out_word_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Mirror of the configuration registers.
  logic [2:0]         cur_mode;
  logic signed [31:0] ctr_x, ctr_y, ctr_z, scale_q16, cos_q30, sin_q30;

  out_word_t  due_vertices[$];
  plan_step_t plan[$];
  int         words_sent    = 0;
  int         words_checked = 0;
  int         mismatches    = 0;
  int         settings      = 0;

  vertex_shift_scale_rotate_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic signed [31:0] sat32(input wide_t v);
    if (v > I32_MAX) return I32_MAX;
    if (v < I32_MIN) return I32_MIN;
    return v[31:0];
  endfunction

  // floor((c1*a + c2*b) / 2^30), saturated; the sum is formed at full width.
  function automatic logic signed [31:0] rotate_pair(input wide_t c1, a, c2, b);
    return sat32((c1 * a + c2 * b) >>> 30);
  endfunction

  // (v - p) * k in Q16.16 plus p; only the final sum saturates.
  function automatic logic signed [31:0] scale_coord(input wide_t v, p, k);
    return sat32((((v - p) * k) >>> 16) + p);
  endfunction

  function automatic out_word_t transform_vertex(input in_word_t v);
    out_word_t r;
    wide_t x, y, z, px, py, pz, k, c, s;
    x  = $signed(v.x_in);
    y  = $signed(v.y_in);
    z  = $signed(v.z_in);
    px = ctr_x;
    py = ctr_y;
    pz = ctr_z;
    k  = scale_q16;
    c  = cos_q30;
    s  = sin_q30;
    r.x_out    = v.x_in;
    r.y_out    = v.y_in;
    r.z_out    = v.z_in;
    r.last_out = v.last_in;
    case (cur_mode)
      MODE_SHIFT: begin
        r.x_out = sat32(x - px);
        r.y_out = sat32(y - py);
        r.z_out = sat32(z - pz);
      end
      MODE_SCALE: begin
        r.x_out = scale_coord(x, px, k);
        r.y_out = scale_coord(y, py, k);
        r.z_out = scale_coord(z, pz, k);
      end
      MODE_ROT_X: begin
        r.y_out = rotate_pair(c, y, s, z);
        r.z_out = rotate_pair(-s, y, c, z);
      end
      MODE_ROT_Y: begin
        r.x_out = rotate_pair(c, x, s, z);
        r.z_out = rotate_pair(-s, x, c, z);
      end
      MODE_ROT_Z: begin
        r.x_out = rotate_pair(c, x, s, y);
        r.y_out = rotate_pair(-s, x, c, y);
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic in_word_t vtx(input logic [31:0] x, y, z, input logic last);
    in_word_t w;
    w.x_in    = x;
    w.y_in    = y;
    w.z_in    = z;
    w.last_in = last;
    return w;
  endfunction

  function automatic void plan_write(input logic [2:0] idx, input logic [31:0] val);
    plan_step_t p;
    p = '{default: '0};
    p.is_write = 1'b1;
    p.reg_idx  = idx;
    p.reg_val  = val;
    plan.push_back(p);
  endfunction

  function automatic void plan_vertex(input in_word_t v, input logic typed,
                                      input out_word_t want);
    plan_step_t p;
    p = '{default: '0};
    p.vertex = v;
    p.typed  = typed;
    p.want   = want;
    plan.push_back(p);
  endfunction

  // Full-range values half the time, with the rails and small magnitudes
  // mixed in so that scaling and rotation do not saturate every time.
  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 9))
      0:       return I32_MIN;
      1:       return I32_MAX;
      2, 3, 4: return $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] pick_q16();
    case ($urandom_range(0, 9))
      0:       return I32_MIN;
      1:       return I32_MAX;
      2:       return '0;
      3:       return SCALE_ONE;
      4, 5, 6: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] pick_trig();
    case ($urandom_range(0, 9))
      0:       return TRIG_ONE;
      1:       return -TRIG_ONE;
      2:       return '0;
      3:       return $urandom();
      default: return $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
    endcase
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      REG_MODE:     cur_mode  = data[2:0];
      REG_CENTER_X: ctr_x     = data;
      REG_CENTER_Y: ctr_y     = data;
      REG_CENTER_Z: ctr_z     = data;
      REG_SCALE:    scale_q16 = data;
      REG_COS:      cos_q30   = data;
      REG_SIN:      sin_q30   = data;
      default: ;
    endcase
  endtask

  task automatic send_vertex(input in_word_t v, input logic typed, input out_word_t want);
    // A register write stays on the port until the next word goes out.
    cfg_we  <= 1'b0;
    start   <= 1'b1;
    in_data <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    due_vertices.push_back(typed ? want : transform_vertex(v));
    words_sent++;
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (due_vertices.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin : check_results
    out_word_t want;
    if (rst_n && out_valid) begin
      words_checked++;
      if (due_vertices.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOWN_ERRORS)
          $display("%0t: result word with nothing pending: x=%h y=%h z=%h last=%b",
                   $time, out_data.x_out, out_data.y_out, out_data.z_out,
                   out_data.last_out);
      end else begin
        want = due_vertices.pop_front();
        if (out_data.x_out !== want.x_out || out_data.y_out !== want.y_out ||
            out_data.z_out !== want.z_out || out_data.last_out !== want.last_out) begin
          mismatches++;
          if (mismatches <= SHOWN_ERRORS)
            $display("%0t: mismatch: want x=%h y=%h z=%h last=%b, got x=%h y=%h z=%h last=%b",
                     $time, want.x_out, want.y_out, want.z_out, want.last_out,
                     out_data.x_out, out_data.y_out, out_data.z_out, out_data.last_out);
        end
      end
    end
  end

  initial begin : stimulus
    in_word_t    v;
    logic [2:0]  phase_mode;
    logic [31:0] rail;
    int          sent, burst, gap, directed;

    // Passthrough after reset, then shift saturation at both rails.
    v = vtx(I32_MAX, I32_MIN, 32'h0, 1'b0);
    plan_vertex(v, 1'b1, out_word_t'(v));
    v = vtx(-1, 1, 32'h5555_5555, 1'b1);
    plan_vertex(v, 1'b1, out_word_t'(v));
    plan_write(REG_CENTER_X, I32_MIN);
    plan_write(REG_CENTER_Y, I32_MAX);
    plan_write(REG_CENTER_Z, 32'h1);
    plan_vertex(vtx(0, 0, I32_MIN, 1'b0), 1'b1,
                out_word_t'(vtx(I32_MAX, 32'h8000_0001, I32_MIN, 1'b0)));
    plan_vertex(vtx(I32_MAX, -1, I32_MAX, 1'b1), 1'b0, '0);

    // Scale about a point: a plain case, the rails, and floor on negatives.
    plan_write(REG_MODE, 32'(MODE_SCALE));
    plan_write(REG_CENTER_X, 32'h0001_0000);
    plan_write(REG_CENTER_Y, 32'hFFFE_0000);
    plan_write(REG_CENTER_Z, 32'h0);
    plan_write(REG_SCALE, 32'h0002_0000);
    plan_vertex(vtx(32'h0003_0000, 32'hFFFE_0000, 0, 1'b1), 1'b1,
                out_word_t'(vtx(32'h0005_0000, 32'hFFFE_0000, 0, 1'b1)));
    plan_vertex(vtx(I32_MAX, I32_MIN, 32'h0000_8001, 1'b0), 1'b0, '0);
    plan_write(REG_SCALE, I32_MIN);
    plan_write(REG_CENTER_X, I32_MIN);
    plan_vertex(vtx(I32_MAX, I32_MIN, -1, 1'b0), 1'b0, '0);
    plan_write(REG_SCALE, I32_MAX);
    plan_vertex(vtx(I32_MIN, I32_MAX, 1, 1'b1), 1'b0, '0);
    plan_write(REG_SCALE, 32'hFFFF_8000);
    plan_vertex(vtx(3, -3, 1, 1'b0), 1'b0, '0);

    // Rotation about each axis at 45 degrees.
    plan_write(REG_MODE, 32'(MODE_ROT_X));
    plan_write(REG_COS, 32'h2D41_3CCD);
    plan_write(REG_SIN, 32'h2D41_3CCD);
    plan_vertex(vtx(32'h0001_0000, 32'h0001_0000, 32'hFFFF_0000, 1'b0), 1'b0, '0);
    plan_vertex(vtx(I32_MAX, I32_MAX, I32_MIN, 1'b1), 1'b0, '0);
    plan_write(REG_MODE, 32'(MODE_ROT_Y));
    plan_vertex(vtx(32'h0002_0000, -5, 32'h0003_0000, 1'b0), 1'b0, '0);
    plan_write(REG_MODE, 32'(MODE_ROT_Z));
    plan_vertex(vtx(I32_MIN, I32_MAX, 7, 1'b1), 1'b0, '0);

    // A quarter turn about Z moves y into x and -x into y.
    plan_write(REG_COS, 32'h0);
    plan_write(REG_SIN, TRIG_ONE);
    plan_vertex(vtx(32'h0001_0000, 32'h0002_0000, 9, 1'b0), 1'b1,
                out_word_t'(vtx(32'h0002_0000, 32'hFFFF_0000, 9, 1'b0)));
    plan_write(REG_COS, -TRIG_ONE);
    plan_write(REG_SIN, 32'h0);
    plan_vertex(vtx(I32_MIN, 5, 0, 1'b1), 1'b0, '0);

    // Trig values well outside +-1.0 push the product sum to its widest.
    plan_write(REG_COS, I32_MIN);
    plan_write(REG_SIN, I32_MIN);
    plan_vertex(vtx(I32_MIN, I32_MIN, 0, 1'b0), 1'b0, '0);

    // Spare mode codes pass the vertex through; an index past sine changes nothing.
    plan_write(REG_MODE, 32'(MODE_SPARE_LO));
    v = vtx(I32_MIN, -1, I32_MAX, 1'b1);
    plan_vertex(v, 1'b1, out_word_t'(v));
    plan_write(REG_MODE, 32'(MODE_SPARE_HI));
    v = vtx(32'h1234_5678, 0, 32'h8000_0001, 1'b0);
    plan_vertex(v, 1'b1, out_word_t'(v));
    plan_write(REG_NONE, 32'h0);
    v = vtx(32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF, 1'b1);
    plan_vertex(v, 1'b1, out_word_t'(v));

    // Only the low three bits of a mode write count.
    plan_write(REG_MODE, {29'h1FFF_FFFF, MODE_SHIFT});
    plan_vertex(vtx(32'h0000_0001, I32_MIN, 32'h7FFF_0000, 1'b0), 1'b0, '0);

    repeat (9) @(posedge clk);
    rst_n     <= 1'b1;
    cur_mode  = MODE_SHIFT;
    ctr_x     = '0;
    ctr_y     = '0;
    ctr_z     = '0;
    scale_q16 = SCALE_ONE;
    cos_q30   = TRIG_ONE;
    sin_q30   = '0;

    settings = 1;
    foreach (plan[i]) begin
      if (plan[i].is_write) begin
        if (start || due_vertices.size() != 0) begin
          wait_idle();
          settings++;
        end
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        send_vertex(plan[i].vertex, plan[i].typed, plan[i].want);
      end
    end
    directed = words_sent;

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      settings++;
      // First eight settings walk every mode code; the rest rail center and scale.
      if (ph < 8) phase_mode = 3'(ph);
      else phase_mode = 3'($urandom_range(MODE_SHIFT, MODE_ROT_Z));
      write_reg(REG_MODE, {29'($urandom()), phase_mode});
      if (ph < 8) begin
        write_reg(REG_CENTER_X, pick_q16());
        write_reg(REG_CENTER_Y, pick_q16());
        write_reg(REG_CENTER_Z, pick_q16());
        write_reg(REG_SCALE, pick_q16());
        write_reg(REG_COS, pick_trig());
        write_reg(REG_SIN, pick_trig());
      end else begin
        rail = ($urandom_range(0, 1) != 0) ? I32_MAX : I32_MIN;
        write_reg(REG_CENTER_X, rail);
        write_reg(REG_CENTER_Y, ~rail);
        write_reg(REG_CENTER_Z, rail);
        write_reg(REG_SCALE, rail);
        write_reg(REG_COS, (ph % 2 != 0) ? TRIG_ONE : -TRIG_ONE);
        write_reg(REG_SIN, (ph >= 10) ? rail : TRIG_ONE);
      end
      if ($urandom_range(0, 3) == 0) write_reg(REG_NONE, $urandom());

      sent = 0;
      while (sent < PHASE_WORDS) begin
        burst = $urandom_range(1, 40);
        for (int k = 0; k < burst && sent < PHASE_WORDS; k++) begin
          send_vertex(vtx(pick_coord(), pick_coord(), pick_coord(),
                          1'($urandom_range(0, 1))), 1'b0, '0);
          sent++;
        end
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap > 0) begin
          start <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end

    wait_idle();
    repeat (8) @(posedge clk);

    $display("Sent %0d vertices (%0d directed, the rest random in bursts) over %0d",
             words_sent, directed, settings);
    $display("register settings covering all five modes, the spare codes and the rails.");
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d of %0d result words were wrong or unexpected.", mismatches,
               words_checked);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
